/* rtl/mts_pkg.sv */
// Shared types, codes and pattern functions of the memory test sequencer.
package mts_pkg;

    localparam logic [31:0] BASE_ADDRESS = 32'h0000_0000;
    localparam logic [20:0] FULL_WORDS   = 21'd1048576;

    localparam logic [31:0] PAT_DEADBEEF = 32'hDEAD_BEEF;
    localparam logic [31:0] PAT_AA       = 32'hAAAA_AAAA;
    localparam logic [31:0] PAT_55       = 32'h5555_5555;
    localparam logic [31:0] PAT_ONES     = 32'hFFFF_FFFF;
    localparam logic [5:0]  WALK_STEPS   = 6'd32;

    // register indexes
    localparam logic [2:0] CFG_TEST_KIND      = 3'd0;
    localparam logic [2:0] CFG_PATTERN_MODE   = 3'd1;
    localparam logic [2:0] CFG_WORD_COUNT     = 3'd2;
    localparam logic [2:0] CFG_WORD_STEP      = 3'd3;
    localparam logic [2:0] CFG_READS_PER_WORD = 3'd4;

    localparam logic TK_QUICK  = 1'b0;
    localparam logic TK_DETAIL = 1'b1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DONE  = 1'b1;

    // quick test patterns
    localparam logic [2:0] QP_ZEROS    = 3'd0;
    localparam logic [2:0] QP_ONES     = 3'd1;
    localparam logic [2:0] QP_DEADBEEF = 3'd2;
    localparam logic [2:0] QP_WALK1    = 3'd3;
    localparam logic [2:0] QP_AA       = 3'd4;

    // detail test pattern sets
    localparam logic [2:0] DP_A5    = 3'd0;
    localparam logic [2:0] DP_WALK1 = 3'd1;
    localparam logic [2:0] DP_WALK0 = 3'd2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_IDLE   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_QWRITE = 4'b0010,
        PH_QREAD  = 4'b0100,
        PH_DETAIL = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        test_kind;
        logic [2:0]  pattern_mode;
        logic [20:0] word_count;
        logic [20:0] word_step;
        logic [7:0]  reads_per_word;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        checked;
        logic        mismatch;
        logic [31:0] checked_address;
        logic [31:0] error_count;
        logic [20:0] words_tested;
    } t_result;

    function automatic logic [20:0] eff_count(input t_cfg cfg);
        logic [20:0] c;
        c = cfg.word_count;
        if (c == 21'd0 || c > FULL_WORDS) begin
            c = FULL_WORDS;
        end
        return c;
    endfunction

    function automatic logic [20:0] eff_step(input t_cfg cfg);
        return (cfg.word_step == 21'd0) ? 21'd1 : cfg.word_step;
    endfunction

    function automatic logic [31:0] quick_pattern(input logic [2:0] mode,
                                                  input logic [4:0] idx);
        logic [31:0] p;
        case (mode)
            QP_ONES:     p = PAT_ONES;
            QP_DEADBEEF: p = PAT_DEADBEEF;
            QP_WALK1:    p = 32'd1 << idx;
            QP_AA:       p = PAT_AA;
            default:     p = 32'd0;
        endcase
        return p;
    endfunction

    function automatic logic [5:0] detail_count(input logic [2:0] mode);
        logic [5:0] n;
        case (mode)
            DP_A5:    n = 6'd2;
            DP_WALK1: n = WALK_STEPS;
            DP_WALK0: n = WALK_STEPS;
            default:  n = 6'd1;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] detail_pattern(input logic [2:0] mode,
                                                   input logic [4:0] s);
        logic [31:0] p;
        case (mode)
            DP_A5:    p = s[0] ? PAT_AA : PAT_55;
            DP_WALK1: p = 32'd1 << s;
            DP_WALK0: p = ~(32'd1 << s);
            default:  p = 32'd0;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] word_address(input logic [20:0] idx);
        return BASE_ADDRESS + {9'd0, idx, 2'b00};
    endfunction

endpackage

/* rtl/mts_if.sv */
// Handshake channel interfaces of the memory test sequencer.
interface mts_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] read_data;

    modport source (output valid, output action, output read_data, input ready);
    modport sink   (input valid, input action, input read_data, output ready);
endinterface

interface mts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        checked;
    logic        mismatch;
    logic [31:0] checked_address;
    logic [31:0] error_count;
    logic [20:0] words_tested;

    modport source (output valid, output command, output address, output write_data,
                    output checked, output mismatch, output checked_address,
                    output error_count, output words_tested, input ready);
    modport sink   (input valid, input command, input address, input write_data,
                    input checked, input mismatch, input checked_address,
                    input error_count, input words_tested, output ready);
endinterface

interface mts_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [20:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mts_seq.sv */
// Test sequencer state and the next-access logic for one request.
module mts_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mts_pkg::t_cfg     i_cfg,
    input  logic              i_fire,
    input  logic              i_action,
    input  logic [31:0]       i_read_data,
    output mts_pkg::t_result  o_result
);
    import mts_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [20:0] r_word,    n_word;
    logic [4:0]  r_sub,     n_sub;
    logic [7:0]  r_rd,      n_rd;
    logic [31:0] r_errs,    n_errs;
    logic        r_pend_rd, n_pend_rd;
    logic [31:0] r_pend_addr, n_pend_addr;
    logic [31:0] r_pend_exp,  n_pend_exp;

    logic [20:0] cnt;
    logic [21:0] nw_sum;
    logic        nw_ok;
    logic        rd_more;
    logic        sub_more;
    logic        do_issue;
    logic        iss_rd;
    logic [31:0] iss_data;
    logic        do_finish;
    logic        do_dnext;
    t_result     res;

    assign cnt      = eff_count(i_cfg);
    assign nw_sum   = {1'b0, r_word} + {1'b0, eff_step(i_cfg)};
    assign nw_ok    = nw_sum < {1'b0, cnt};
    assign rd_more  = ({1'b0, r_rd} + 9'd1) < {1'b0, i_cfg.reads_per_word};
    assign sub_more = ({1'b0, r_sub} + 6'd1) < detail_count(i_cfg.pattern_mode);

    always_comb begin
        n_phase     = r_phase;
        n_word      = r_word;
        n_sub       = r_sub;
        n_rd        = r_rd;
        n_errs      = r_errs;
        n_pend_rd   = r_pend_rd;
        n_pend_addr = r_pend_addr;
        n_pend_exp  = r_pend_exp;
        do_issue    = 1'b0;
        iss_rd      = 1'b0;
        iss_data    = 32'd0;
        do_finish   = 1'b0;
        do_dnext    = 1'b0;
        res         = '0;

        if (i_action == ACT_START) begin
            n_errs = 32'd0;
            n_word = 21'd0;
            n_sub  = 5'd0;
            n_rd   = 8'd0;
            do_issue = 1'b1;
            if (i_cfg.test_kind == TK_QUICK) begin
                n_phase  = PH_QWRITE;
                iss_data = quick_pattern(i_cfg.pattern_mode, 5'd0);
            end else begin
                n_phase  = PH_DETAIL;
                iss_data = detail_pattern(i_cfg.pattern_mode, 5'd0);
            end
        end else if (r_phase == PH_IDLE) begin
            res.command = CMD_IDLE;
        end else begin
            // check the read issued last
            if (r_pend_rd) begin
                res.checked         = 1'b1;
                res.checked_address = r_pend_addr;
                if (i_read_data != r_pend_exp) begin
                    res.mismatch = 1'b1;
                    if (r_errs != PAT_ONES) begin
                        n_errs = r_errs + 32'd1;
                    end
                end
            end

            case (r_phase)
                PH_QWRITE: begin
                    if (nw_ok) begin
                        n_word   = nw_sum[20:0];
                        do_issue = 1'b1;
                        iss_data = quick_pattern(i_cfg.pattern_mode, nw_sum[4:0]);
                    end else begin
                        n_phase = PH_QREAD;
                        n_word  = 21'd0;
                        n_rd    = 8'd0;
                        if (i_cfg.reads_per_word == 8'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            do_issue = 1'b1;
                            iss_rd   = 1'b1;
                            iss_data = quick_pattern(i_cfg.pattern_mode, 5'd0);
                        end
                    end
                end
                PH_QREAD: begin
                    if (rd_more) begin
                        n_rd     = r_rd + 8'd1;
                        do_issue = 1'b1;
                        iss_rd   = 1'b1;
                        iss_data = quick_pattern(i_cfg.pattern_mode, r_word[4:0]);
                    end else begin
                        n_rd = 8'd0;
                        if (i_cfg.reads_per_word != 8'd0 && nw_ok) begin
                            n_word   = nw_sum[20:0];
                            do_issue = 1'b1;
                            iss_rd   = 1'b1;
                            iss_data = quick_pattern(i_cfg.pattern_mode, nw_sum[4:0]);
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                end
                PH_DETAIL: begin
                    if (!r_pend_rd) begin
                        n_rd = 8'd0;
                        if (i_cfg.reads_per_word != 8'd0) begin
                            do_issue = 1'b1;
                            iss_rd   = 1'b1;
                            iss_data = r_pend_exp;
                        end else begin
                            do_dnext = 1'b1;
                        end
                    end else if (rd_more) begin
                        n_rd     = r_rd + 8'd1;
                        do_issue = 1'b1;
                        iss_rd   = 1'b1;
                        iss_data = r_pend_exp;
                    end else begin
                        n_rd     = 8'd0;
                        do_dnext = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // advance to the next sub-pattern, or the next word
            if (do_dnext) begin
                if (sub_more) begin
                    n_sub    = r_sub + 5'd1;
                    do_issue = 1'b1;
                    iss_data = detail_pattern(i_cfg.pattern_mode, r_sub + 5'd1);
                end else begin
                    n_sub = 5'd0;
                    if (nw_ok) begin
                        n_word   = nw_sum[20:0];
                        do_issue = 1'b1;
                        iss_data = detail_pattern(i_cfg.pattern_mode, 5'd0);
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
        end

        if (do_issue) begin
            n_pend_rd      = iss_rd;
            n_pend_addr    = word_address(n_word);
            n_pend_exp     = iss_data;
            res.command    = iss_rd ? CMD_READ : CMD_WRITE;
            res.address    = word_address(n_word);
            res.write_data = iss_data;
        end
        if (do_finish) begin
            n_phase          = PH_IDLE;
            n_pend_rd        = 1'b0;
            res.command      = CMD_FINISH;
            res.words_tested = cnt;
        end
        res.error_count = n_errs;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_word      <= 21'd0;
            r_sub       <= 5'd0;
            r_rd        <= 8'd0;
            r_errs      <= 32'd0;
            r_pend_rd   <= 1'b0;
            r_pend_addr <= 32'd0;
            r_pend_exp  <= 32'd0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_word      <= n_word;
            r_sub       <= n_sub;
            r_rd        <= n_rd;
            r_errs      <= n_errs;
            r_pend_rd   <= n_pend_rd;
            r_pend_addr <= n_pend_addr;
            r_pend_exp  <= n_pend_exp;
        end
    end

endmodule

/* rtl/memory_test_sequencer.sv */
// Top level of the memory test sequencer: configuration, handshake and result register.
// Memory test sequencer. A start request begins a quick or detail test; every
// access-completed request returns the read data of the last access, which is
// compared with the expected pattern, and the block answers with the next
// write or read command (or finished, or idle). One request is taken every
// clock cycle; its answer enters the output register on acceptance, and the
// next request is taken while that answer waits, as long as the sink takes
// it in the same cycle. The rate is set by the single pass through the
// next-access logic (21-bit word step add and compare) between the sequencer
// state and the output register. Configuration writes are always accepted
// and should be issued while no request is in flight.
module memory_test_sequencer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mts_in_if.sink   i_in,
    mts_cfg_if.sink  i_cfg,
    mts_out_if.source o_out
);
    import mts_pkg::*;

    t_cfg    r_cfg;
    t_result r_res;
    logic    r_out_valid;
    t_result seq_res;
    logic    fire;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign fire        = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.test_kind      <= TK_QUICK;
            r_cfg.pattern_mode   <= QP_ZEROS;
            r_cfg.word_count     <= 21'd0;
            r_cfg.word_step      <= 21'd1;
            r_cfg.reads_per_word <= 8'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TEST_KIND:      r_cfg.test_kind      <= i_cfg.data[0];
                CFG_PATTERN_MODE:   r_cfg.pattern_mode   <= i_cfg.data[2:0];
                CFG_WORD_COUNT:     r_cfg.word_count     <= i_cfg.data;
                CFG_WORD_STEP:      r_cfg.word_step      <= i_cfg.data;
                CFG_READS_PER_WORD: r_cfg.reads_per_word <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    mts_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fire      (fire),
        .i_action    (i_in.action),
        .i_read_data (i_in.read_data),
        .o_result    (seq_res)
    );

    // hold the answer until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= seq_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.command         = r_res.command;
    assign o_out.address         = r_res.address;
    assign o_out.write_data      = r_res.write_data;
    assign o_out.checked         = r_res.checked;
    assign o_out.mismatch        = r_res.mismatch;
    assign o_out.checked_address = r_res.checked_address;
    assign o_out.error_count     = r_res.error_count;
    assign o_out.words_tested    = r_res.words_tested;

endmodule

/* tb/memory_test_sequencer_tb.sv */
// Self-checking testbench of the memory test sequencer: directed table, then random tests.
`timescale 1ns / 1ps

module memory_test_sequencer_tb;
    import mts_pkg::*;

    localparam int IDLE_PCT       = 26;
    localparam int TOTAL_REQUESTS = 550;
    localparam int DRAIN_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mts_in_if  in_if ();
    mts_out_if out_if ();
    mts_cfg_if cfg_if ();

    memory_test_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the registers and the sequencer state
    t_cfg        shadow_cfg;
    t_phase      tst_phase;
    logic [20:0] word_idx;
    logic [5:0]  sub_idx;
    logic [7:0]  rd_idx;
    logic [31:0] err_total;
    logic        last_was_read;
    logic [31:0] last_addr;
    logic [31:0] last_pattern;
    t_result     next_resp;

    t_result due_responses[$];

    bit steady = 1'b0;
    int fail_cnt = 0;
    int requests_sent = 0;
    int tests_finished = 0;
    int reads_compared = 0;
    int miscompares = 0;
    int quiet_cycles = 0;

    typedef struct {
        logic        is_reg;
        logic [2:0]  reg_idx;
        logic [20:0] reg_val;
        logic        act;
        logic [31:0] data;
        logic        echo;    // answer with the pattern the pending read expects
        logic        typed;
        t_result     want;
    } t_row;

    t_row plan[$];

    // ---------------- predictor ----------------

    function automatic logic [20:0] span_words();
        logic [20:0] c;
        c = shadow_cfg.word_count;
        if (c == 21'd0 || c > FULL_WORDS) c = FULL_WORDS;
        return c;
    endfunction

    function automatic logic [20:0] stride_words();
        return (shadow_cfg.word_step == 21'd0) ? 21'd1 : shadow_cfg.word_step;
    endfunction

    function automatic logic [31:0] quick_word(input logic [20:0] idx);
        case (shadow_cfg.pattern_mode)
            QP_ONES:     return PAT_ONES;
            QP_DEADBEEF: return PAT_DEADBEEF;
            QP_WALK1:    return 32'd1 << idx[4:0];
            QP_AA:       return PAT_AA;
            default:     return 32'd0;
        endcase
    endfunction

    function automatic logic [6:0] pattern_steps();
        case (shadow_cfg.pattern_mode)
            DP_A5:    return 7'd2;
            DP_WALK1: return 7'(WALK_STEPS);
            DP_WALK0: return 7'(WALK_STEPS);
            default:  return 7'd1;
        endcase
    endfunction

    function automatic logic [31:0] sub_pattern(input logic [5:0] s);
        case (shadow_cfg.pattern_mode)
            DP_A5:    return s[0] ? PAT_AA : PAT_55;
            DP_WALK1: return 32'd1 << s[4:0];
            DP_WALK0: return ~(32'd1 << s[4:0]);
            default:  return 32'd0;
        endcase
    endfunction

    function automatic void issue_access(input logic rd, input logic [31:0] pattern);
        last_was_read = rd;
        last_addr = BASE_ADDRESS + (32'(word_idx) << 2);
        last_pattern = pattern;
        next_resp.command = rd ? CMD_READ : CMD_WRITE;
        next_resp.address = last_addr;
        next_resp.write_data = pattern;
    endfunction

    function automatic void close_test();
        tst_phase = PH_IDLE;
        last_was_read = 1'b0;
        next_resp.command = CMD_FINISH;
        next_resp.words_tested = span_words();
    endfunction

    // step to the next word; false once the range is exhausted
    function automatic logic advance_word();
        logic [31:0] n;
        n = 32'(word_idx) + 32'(stride_words());
        if (n >= 32'(span_words())) return 1'b0;
        word_idx = n[20:0];
        return 1'b1;
    endfunction

    function automatic void next_sub_pattern();
        if (7'(sub_idx) + 7'd1 < pattern_steps()) begin
            sub_idx = sub_idx + 6'd1;
            issue_access(1'b0, sub_pattern(sub_idx));
        end else begin
            sub_idx = 6'd0;
            if (advance_word()) issue_access(1'b0, sub_pattern(6'd0));
            else close_test();
        end
    endfunction

    function automatic void predict_next_access(input logic act, input logic [31:0] rd);
        logic was_read;
        next_resp = '0;
        if (act == ACT_START) begin
            err_total = 32'd0;
            word_idx = 21'd0;
            sub_idx = 6'd0;
            rd_idx = 8'd0;
            if (shadow_cfg.test_kind == TK_QUICK) begin
                tst_phase = PH_QWRITE;
                issue_access(1'b0, quick_word(21'd0));
            end else begin
                tst_phase = PH_DETAIL;
                issue_access(1'b0, sub_pattern(6'd0));
            end
        end else if (tst_phase == PH_IDLE) begin
            next_resp.command = CMD_IDLE;
        end else begin
            was_read = last_was_read;
            if (was_read) begin
                next_resp.checked = 1'b1;
                next_resp.checked_address = last_addr;
                if (rd != last_pattern) begin
                    next_resp.mismatch = 1'b1;
                    if (err_total != '1) err_total = err_total + 32'd1;
                end
            end
            case (tst_phase)
                PH_QWRITE: begin
                    if (advance_word()) begin
                        issue_access(1'b0, quick_word(word_idx));
                    end else begin
                        tst_phase = PH_QREAD;
                        word_idx = 21'd0;
                        rd_idx = 8'd0;
                        if (shadow_cfg.reads_per_word == 8'd0) close_test();
                        else issue_access(1'b1, quick_word(21'd0));
                    end
                end
                PH_QREAD: begin
                    if (9'(rd_idx) + 9'd1 < 9'(shadow_cfg.reads_per_word)) begin
                        rd_idx = rd_idx + 8'd1;
                        issue_access(1'b1, quick_word(word_idx));
                    end else begin
                        rd_idx = 8'd0;
                        if (shadow_cfg.reads_per_word != 8'd0 && advance_word())
                            issue_access(1'b1, quick_word(word_idx));
                        else
                            close_test();
                    end
                end
                default: begin
                    if (!was_read) begin
                        rd_idx = 8'd0;
                        if (shadow_cfg.reads_per_word != 8'd0) issue_access(1'b1, last_pattern);
                        else next_sub_pattern();
                    end else if (9'(rd_idx) + 9'd1 < 9'(shadow_cfg.reads_per_word)) begin
                        rd_idx = rd_idx + 8'd1;
                        issue_access(1'b1, last_pattern);
                    end else begin
                        rd_idx = 8'd0;
                        next_sub_pattern();
                    end
                end
            endcase
        end
        next_resp.error_count = err_total;
    endfunction

    // ---------------- table helpers ----------------

    function automatic t_result result_of(input logic [1:0] cmd, input logic [31:0] addr,
                                          input logic [31:0] wdata, input logic chk,
                                          input logic mis, input logic [31:0] caddr,
                                          input logic [31:0] errs, input logic [20:0] words);
        t_result r;
        r.command = cmd;
        r.address = addr;
        r.write_data = wdata;
        r.checked = chk;
        r.mismatch = mis;
        r.checked_address = caddr;
        r.error_count = errs;
        r.words_tested = words;
        return r;
    endfunction

    function automatic void plan_reg(input logic [2:0] idx, input logic [20:0] val);
        t_row r;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.act = ACT_DONE;
        r.data = 32'd0;
        r.echo = 1'b0;
        r.typed = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_req(input logic act, input logic [31:0] data,
                                     input logic echo);
        t_row r;
        r.is_reg = 1'b0;
        r.reg_idx = CFG_TEST_KIND;
        r.reg_val = 21'd0;
        r.act = act;
        r.data = data;
        r.echo = echo;
        r.typed = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_fixed(input logic act, input logic [31:0] data,
                                       input t_result want);
        t_row r;
        r.is_reg = 1'b0;
        r.reg_idx = CFG_TEST_KIND;
        r.reg_val = 21'd0;
        r.act = act;
        r.data = data;
        r.echo = 1'b0;
        r.typed = 1'b1;
        r.want = want;
        plan.push_back(r);
    endfunction

    // ---------------- channel tasks ----------------

    task automatic send_req(input logic act, input logic [31:0] data, input logic typed,
                            input t_result want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.action <= act;
        in_if.read_data <= data;
        do @(posedge i_clk); while (!in_if.ready);
        if (act == ACT_START || tst_phase != PH_IDLE) requests_sent++;
        predict_next_access(act, data);
        if (next_resp.command == CMD_FINISH) tests_finished++;
        if (next_resp.checked) reads_compared++;
        if (next_resp.mismatch) miscompares++;
        due_responses.push_back(typed ? want : next_resp);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_TEST_KIND:      shadow_cfg.test_kind = val[0];
            CFG_PATTERN_MODE:   shadow_cfg.pattern_mode = val[2:0];
            CFG_WORD_COUNT:     shadow_cfg.word_count = val;
            CFG_WORD_STEP:      shadow_cfg.word_step = val;
            CFG_READS_PER_WORD: shadow_cfg.reads_per_word = val[7:0];
            default: ;
        endcase
    endtask

    // drop the request, wait for every answer, then let the pipeline drain
    task automatic settle();
        in_if.valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_read_data();
        int k;
        k = $urandom_range(99);
        if (!last_was_read || k < 8) return $urandom();
        if (k < 15) return last_pattern ^ (32'd1 << $urandom_range(31));
        return last_pattern;
    endfunction

    // ---------------- checking ----------------

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            if (fail_cnt < 40) $error("%s: expected %h, got %h", name, exp_val, got_val);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : response_check
        t_result w;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (due_responses.size() == 0) begin
                if (fail_cnt < 40) $error("response with nothing due: command %0d",
                                          out_if.command);
                fail_cnt++;
            end else begin
                w = due_responses.pop_front();
                check_field("command", 32'(w.command), 32'(out_if.command));
                check_field("address", w.address, out_if.address);
                check_field("write_data", w.write_data, out_if.write_data);
                check_field("checked", 32'(w.checked), 32'(out_if.checked));
                check_field("mismatch", 32'(w.mismatch), 32'(out_if.mismatch));
                check_field("checked_address", w.checked_address, out_if.checked_address);
                check_field("error_count", w.error_count, out_if.error_count);
                check_field("words_tested", 32'(w.words_tested), 32'(out_if.words_tested));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: %0d responses still due", due_responses.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // response backpressure
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        logic        prev_reg;
        logic        kind;
        logic [2:0]  mode;
        logic [20:0] cnt;
        logic [20:0] stp;
        logic [7:0]  reads;
        int          k;
        int          cap;
        int          n;
        int          phase_no;

        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.action = ACT_START;
        in_if.read_data = 32'd0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_TEST_KIND;
        cfg_if.data = 21'd0;

        shadow_cfg.test_kind = TK_QUICK;
        shadow_cfg.pattern_mode = QP_ZEROS;
        shadow_cfg.word_count = 21'd0;
        shadow_cfg.word_step = 21'd1;
        shadow_cfg.reads_per_word = 8'd1;
        tst_phase = PH_IDLE;
        word_idx = 21'd0;
        sub_idx = 6'd0;
        rd_idx = 8'd0;
        err_total = 32'd0;
        last_was_read = 1'b0;
        last_addr = 32'd0;
        last_pattern = 32'd0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // completion with no test running
        plan_fixed(ACT_DONE, 32'hFFFF_FFFF, result_of(CMD_IDLE, 0, 0, 0, 0, 0, 0, 0));
        // two-word quick test, one good and one bad read
        plan_reg(CFG_WORD_COUNT, 21'd2);
        plan_reg(CFG_PATTERN_MODE, 21'(QP_DEADBEEF));
        plan_fixed(ACT_START, 32'd0, result_of(CMD_WRITE, 0, PAT_DEADBEEF, 0, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, 32'hFFFF_FFFF,
                   result_of(CMD_WRITE, 32'd4, PAT_DEADBEEF, 0, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, 32'd0, result_of(CMD_READ, 0, PAT_DEADBEEF, 0, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, PAT_DEADBEEF,
                   result_of(CMD_READ, 32'd4, PAT_DEADBEEF, 1, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, 32'd0, result_of(CMD_FINISH, 0, 0, 1, 1, 32'd4, 32'd1, 21'd2));
        plan_fixed(ACT_DONE, 32'd0, result_of(CMD_IDLE, 0, 0, 0, 0, 0, 32'd1, 0));
        // detail A/5 with no reads, oversized count and a step past the end
        plan_reg(CFG_TEST_KIND, 21'(TK_DETAIL));
        plan_reg(CFG_PATTERN_MODE, 21'(DP_A5));
        plan_reg(CFG_WORD_COUNT, 21'h1F_FFFF);
        plan_reg(CFG_WORD_STEP, 21'h1F_FFFF);
        plan_reg(CFG_READS_PER_WORD, 21'd0);
        plan_fixed(ACT_START, 32'd0, result_of(CMD_WRITE, 0, PAT_55, 0, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, 32'd0, result_of(CMD_WRITE, 0, PAT_AA, 0, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, 32'd0, result_of(CMD_FINISH, 0, 0, 0, 0, 0, 0, FULL_WORDS));
        // quick test over the full memory, top word reached, no reads
        plan_reg(CFG_TEST_KIND, 21'(TK_QUICK));
        plan_reg(CFG_PATTERN_MODE, 21'(QP_ONES));
        plan_reg(CFG_WORD_COUNT, 21'd0);
        plan_reg(CFG_WORD_STEP, 21'h0F_FFFF);
        plan_fixed(ACT_START, 32'd0, result_of(CMD_WRITE, 0, PAT_ONES, 0, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, 32'd0,
                   result_of(CMD_WRITE, 32'h003F_FFFC, PAT_ONES, 0, 0, 0, 0, 0));
        plan_fixed(ACT_DONE, 32'd0, result_of(CMD_FINISH, 0, 0, 0, 0, 0, 0, FULL_WORDS));
        // walking one with zero step, restarted while running
        plan_reg(CFG_PATTERN_MODE, 21'(QP_WALK1));
        plan_reg(CFG_WORD_COUNT, 21'd3);
        plan_reg(CFG_WORD_STEP, 21'd0);
        plan_reg(CFG_READS_PER_WORD, 21'd2);
        plan_req(ACT_START, 32'd0, 1'b0);
        plan_req(ACT_DONE, 32'd0, 1'b0);
        plan_req(ACT_START, 32'hFFFF_FFFF, 1'b0);
        plan_req(ACT_DONE, 32'd0, 1'b0);
        plan_req(ACT_DONE, 32'd0, 1'b0);
        plan_req(ACT_DONE, 32'd0, 1'b0);
        plan_req(ACT_DONE, 32'd0, 1'b1);
        plan_req(ACT_DONE, 32'd0, 1'b0);
        plan_req(ACT_DONE, 32'd0, 1'b1);
        plan_req(ACT_DONE, 32'd0, 1'b1);
        plan_req(ACT_DONE, 32'd0, 1'b1);
        plan_req(ACT_DONE, 32'd0, 1'b1);

        prev_reg = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (!prev_reg) settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                if (prev_reg) cfg_if.valid <= 1'b0;
                send_req(plan[i].act, plan[i].echo ? last_pattern : plan[i].data,
                         plan[i].typed, plan[i].want);
            end
            prev_reg = plan[i].is_reg;
        end

        // random tests: new settings with no request in flight, then a start and completions
        phase_no = 0;
        while (requests_sent < TOTAL_REQUESTS) begin
            settle();
            steady = (phase_no >= 4 && phase_no < 8);

            kind = 1'($urandom_range(1));
            if ($urandom_range(3) == 0) mode = 3'($urandom_range(7));
            else mode = kind ? 3'($urandom_range(2)) : 3'($urandom_range(4));

            k = $urandom_range(15);
            if (k == 0) begin
                cnt = 21'd0;
                stp = 21'($urandom_range(4, 1)) << 18;
            end else if (k == 1) begin
                cnt = 21'($urandom_range(21'h1F_FFFF, 21'h10_0001));
                stp = 21'($urandom_range(21'h1F_FFFF, 21'h04_0000));
            end else if (k == 2) begin
                cnt = 21'($urandom_range(8, 1));
                stp = 21'd0;
            end else begin
                cnt = 21'($urandom_range(6, 1));
                stp = 21'($urandom_range(3, 1));
            end
            if (kind == TK_DETAIL && (mode == DP_WALK1 || mode == DP_WALK0) && k > 1)
                cnt = 21'($urandom_range(2, 1));

            k = $urandom_range(19);
            if (k == 0) reads = 8'hFF;
            else if (k < 4) reads = 8'd0;
            else reads = 8'($urandom_range(3, 1));

            // unused upper data bits ride along with random content
            if (phase_no == 0 || $urandom_range(2) != 0)
                write_reg(CFG_TEST_KIND, {20'($urandom()), kind});
            if (phase_no == 0 || $urandom_range(2) != 0)
                write_reg(CFG_PATTERN_MODE, {18'($urandom()), mode});
            if (phase_no == 0 || $urandom_range(2) != 0)
                write_reg(CFG_WORD_COUNT, cnt);
            if (phase_no == 0 || $urandom_range(2) != 0)
                write_reg(CFG_WORD_STEP, stp);
            if (phase_no == 0 || $urandom_range(2) != 0)
                write_reg(CFG_READS_PER_WORD, {13'($urandom()), reads});
            cfg_if.valid <= 1'b0;

            // now and then keep the old test running under the new settings
            if (phase_no == 0 || $urandom_range(7) != 0)
                send_req(ACT_START, $urandom(), 1'b0, '0);

            cap = $urandom_range(120, 30);
            n = 0;
            while (tst_phase != PH_IDLE && n < cap) begin
                if ($urandom_range(99) == 0) send_req(ACT_START, $urandom(), 1'b0, '0);
                else send_req(ACT_DONE, pick_read_data(), 1'b0, '0);
                n++;
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(2, 1)) send_req(ACT_DONE, $urandom(), 1'b0, '0);
            phase_no++;
        end

        settle();
        $display("Covered %0d requests in %0d random settings, %0d tests finished.",
                 requests_sent, phase_no, tests_finished);
        $display("Compared %0d reads, %0d of them with injected miscompares.",
                 reads_compared, miscompares);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* memory_test_sequencer.f */
rtl/mts_pkg.sv
rtl/mts_if.sv
rtl/mts_seq.sv
rtl/memory_test_sequencer.sv
tb/memory_test_sequencer_tb.sv
